// ===== rtl/core/gfdt_pkg.sv =====
// Package for the gray fit downscale threshold block.
// Holds widths, register indexes, queue entry and control structs, and side clamping.
// Depends on nothing; every other file of the block imports it.
package gfdt_pkg;

	localparam int SIDE_W      = 13;
	localparam int POS_W       = 12;
	localparam int GRAY_W      = 8;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;
	localparam int PROD_W      = 24;
	localparam int DIV_CNT_W   = $clog2(PROD_W);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SIDE_W-1:0] MAX_SIDE     = 13'd4096;
	localparam logic [GRAY_W-1:0] THRESH_RESET = 8'd128;

	typedef enum logic [1:0] {
		REG_SRC_WIDTH,
		REG_SRC_HEIGHT,
		REG_MAX_SIDE,
		REG_DARK_THRESHOLD
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_MUL,
		ST_SIZE_GO,
		ST_SIZE_WAIT,
		ST_COL_GO,
		ST_COL_WAIT,
		ST_ROW_GO,
		ST_ROW_WAIT
	} back_state_t;

	typedef struct packed {
		logic [SIDE_W-1:0] src_width;
		logic [SIDE_W-1:0] src_height;
		logic [SIDE_W-1:0] max_side;
		logic [GRAY_W-1:0] dark_threshold;
	} cfg_t;

	typedef struct packed {
		logic [GRAY_W-1:0] gray;
		logic [POS_W-1:0]  col;
		logic [POS_W-1:0]  row;
		logic              first;
		logic              row_end;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [SIDE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quot;
		logic [SIDE_W-1:0] rem;
	} div_res_t;

	typedef struct packed {
		logic setup_busy;
		logic setup_done;
		logic pop;
		logic pop_first;
	} back_stat_t;

	// A zero side counts as one, a side beyond the limit saturates.
	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (v > MAX_SIDE) begin
			r = MAX_SIDE;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/gfdt_if.sv =====
// Stream interfaces of the gray fit downscale threshold block: source pixels and results.
// Each carries valid, ready and its payload. Depends on gfdt_pkg.
interface gfdt_pix_if;
	import gfdt_pkg::*;
	logic              valid;
	logic              ready;
	logic [GRAY_W-1:0] gray_level;

	modport source (output valid, output gray_level, input ready);
	modport sink (input valid, input gray_level, output ready);
endinterface

interface gfdt_res_if;
	import gfdt_pkg::*;
	logic             valid;
	logic             ready;
	logic             dark;
	logic [POS_W-1:0] out_col;
	logic [POS_W-1:0] out_row;
	logic             frame_end;

	modport source (output valid, output dark, output out_col, output out_row,
		output frame_end, input ready);
	modport sink (input valid, input dark, input out_col, input out_row,
		input frame_end, output ready);
endinterface

// ===== rtl/core/gray_fit_downscale_threshold.sv =====
// Top level of the gray fit downscale threshold block with its APB register file.
// Instantiates gfdt_front, gfdt_fifo, gfdt_back and gfdt_div. Depends on gfdt_pkg and gfdt_if.
//
// Source pixels stream in raster order at one per clock while the queue has room; each pixel
// that lands on the nearest-neighbour grid of the reduced frame gives one request on the
// result channel, the rest give none. At the first pixel of every frame the back end does the
// size setup (one multiply and up to three 24-step divisions in the shared restoring
// divider) before that pixel leaves the queue; the front end keeps taking pixels until the
// two-entry queue is full. Size and limit registers are sampled at frame start, the
// threshold applies at once.
module gray_fit_downscale_threshold (
	input  logic                          clk,
	input  logic                          arst_n,
	gfdt_pix_if.sink                      pix,
	gfdt_res_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gfdt_pkg::ADDR_W-1:0]   paddr,
	input  logic [gfdt_pkg::DATA_W-1:0]   pwdata,
	output logic [gfdt_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import gfdt_pkg::*;

	cfg_t              cfg_q;
	reg_idx_t          reg_idx;
	logic              push;
	entry_t            push_entry;
	entry_t            head;
	logic              q_valid;
	logic              q_full;
	logic [QCNT_W-1:0] q_level;
	logic              pop;
	div_req_t          div_req;
	div_res_t          div_res;
	back_stat_t        stat;

	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width      <= SIDE_W'(1);
			cfg_q.src_height     <= SIDE_W'(1);
			cfg_q.max_side       <= '0;
			cfg_q.dark_threshold <= THRESH_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_SRC_WIDTH:      cfg_q.src_width      <= pwdata[SIDE_W-1:0];
				REG_SRC_HEIGHT:     cfg_q.src_height     <= pwdata[SIDE_W-1:0];
				REG_MAX_SIDE:       cfg_q.max_side       <= pwdata[SIDE_W-1:0];
				REG_DARK_THRESHOLD: cfg_q.dark_threshold <= pwdata[GRAY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SRC_WIDTH:      prdata = DATA_W'(cfg_q.src_width);
			REG_SRC_HEIGHT:     prdata = DATA_W'(cfg_q.src_height);
			REG_MAX_SIDE:       prdata = DATA_W'(cfg_q.max_side);
			REG_DARK_THRESHOLD: prdata = DATA_W'(cfg_q.dark_threshold);
			default:            prdata = '0;
		endcase
	end

	gfdt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.cfg        (cfg_q),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	gfdt_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_valid    (q_valid),
		.q_full     (q_full),
		.level      (q_level)
	);

	gfdt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	gfdt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop),
		.div_req (div_req),
		.div_res (div_res),
		.res     (res),
		.stat    (stat)
	);

	// Nothing leaves the queue while the frame size is being worked out.
	a_no_pop_in_setup: assert property (@(posedge clk) disable iff (!arst_n)
		stat.setup_busy |-> !stat.pop)
		else $error("queue popped during frame setup");

	// A frame-start pixel is only consumed once its steps are known.
	a_first_after_setup: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pop_first |-> stat.setup_done)
		else $error("frame-start pixel consumed before setup finished");

	// The queue fill level moves by at most one entry per cycle.
	a_level_step: assert property (@(posedge clk) disable iff (!arst_n)
		(q_level == $past(q_level)) || (q_level == QCNT_W'($past(q_level) + 1'b1))
		|| (QCNT_W'(q_level + 1'b1) == $past(q_level)))
		else $error("queue level jumped");

endmodule

// ===== rtl/core/gfdt_div.sv =====
// Shared restoring divider of the back end, one quotient bit per cycle.
// Used for the output size and for the column and row steps. Depends on gfdt_pkg.
module gfdt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gfdt_pkg::div_req_t req,
	output gfdt_pkg::div_res_t res
);
	import gfdt_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0]    quot_q;
	logic [SIDE_W-1:0]    rem_q;
	logic [SIDE_W-1:0]    divisor_q;
	logic [SIDE_W:0]      trial;
	logic                 fits;

	assign trial = {rem_q, quot_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
			quot_q    <= '0;
			rem_q     <= '0;
			divisor_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q    <= 1'b1;
				cnt_q     <= '0;
				quot_q    <= req.dividend;
				rem_q     <= '0;
				divisor_q <= req.divisor;
			end else if (busy_q) begin
				rem_q  <= fits ? SIDE_W'(trial - {1'b0, divisor_q}) : trial[SIDE_W-1:0];
				quot_q <= {quot_q[PROD_W-2:0], fits};
				cnt_q  <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res = '{done: done_q, quot: quot_q, rem: rem_q};

endmodule

// ===== rtl/core/gfdt_fifo.sv =====
// Short queue of classified pixels between the front end and the back end.
// Depends on gfdt_pkg for the entry type and the depth.
module gfdt_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  gfdt_pkg::entry_t              push_entry,
	input  logic                          pop,
	output gfdt_pkg::entry_t              head,
	output logic                          q_valid,
	output logic                          q_full,
	output logic [gfdt_pkg::QCNT_W-1:0]   level
);
	import gfdt_pkg::*;

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_valid = count_q != '0;
	assign q_full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign do_push = push && !q_full;
	assign do_pop  = pop && q_valid;
	assign head    = mem_q[rd_ptr_q];
	assign level   = count_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/gfdt_front.sv =====
// Front end: accepts source pixels, tracks the source raster position and tags
// frame starts and row ends before queuing each pixel. Depends on gfdt_pkg and gfdt_if.
module gfdt_front (
	input  logic             clk,
	input  logic             arst_n,
	gfdt_pix_if.sink         pix,
	input  gfdt_pkg::cfg_t   cfg,
	input  logic             q_full,
	output logic             push,
	output gfdt_pkg::entry_t push_entry
);
	import gfdt_pkg::*;

	logic [POS_W-1:0]  src_col_q;
	logic [POS_W-1:0]  src_row_q;
	logic [SIDE_W-1:0] frame_w_q;
	logic [SIDE_W-1:0] frame_h_q;
	logic              first;
	logic              row_end;
	logic              frame_last;
	logic [SIDE_W-1:0] w_eff;
	logic [SIDE_W-1:0] h_eff;
	logic [SIDE_W-1:0] col_inc;
	logic [SIDE_W-1:0] row_inc;

	assign pix.ready  = !q_full;
	assign push       = pix.valid && !q_full;
	assign first      = (src_col_q == '0) && (src_row_q == '0);
	assign w_eff      = first ? clamp_side(cfg.src_width) : frame_w_q;
	assign h_eff      = first ? clamp_side(cfg.src_height) : frame_h_q;
	assign col_inc    = {1'b0, src_col_q} + SIDE_W'(1);
	assign row_inc    = {1'b0, src_row_q} + SIDE_W'(1);
	assign row_end    = col_inc >= w_eff;
	assign frame_last = row_inc >= h_eff;

	assign push_entry = '{gray: pix.gray_level, col: src_col_q, row: src_row_q,
		first: first, row_end: row_end};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			frame_w_q <= '0;
			frame_h_q <= '0;
		end else if (push) begin
			if (first) begin
				frame_w_q <= w_eff;
				frame_h_q <= h_eff;
			end
			if (row_end) begin
				src_col_q <= '0;
				src_row_q <= frame_last ? '0 : row_inc[POS_W-1:0];
			end else begin
				src_col_q <= col_inc[POS_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/core/gfdt_back.sv =====
// Back end: works out the output size and steps at each frame start through the
// shared divider, then picks pixels and registers results. Depends on gfdt_pkg and gfdt_if.
module gfdt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gfdt_pkg::cfg_t       cfg,
	input  logic                 q_valid,
	input  gfdt_pkg::entry_t     head,
	output logic                 pop,
	output gfdt_pkg::div_req_t   div_req,
	input  gfdt_pkg::div_res_t   div_res,
	gfdt_res_if.source           res,
	output gfdt_pkg::back_stat_t stat
);
	import gfdt_pkg::*;

	back_state_t         state_q;
	back_state_t         state_d;
	logic                setup_go;
	logic                setup_done_q;
	logic [SIDE_W-1:0]   w_q;
	logic [SIDE_W-1:0]   h_q;
	logic [SIDE_W-1:0]   m_q;
	logic                short_is_h_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SIDE_W-1:0]   divisor_q;
	logic [SIDE_W-1:0]   dw_q;
	logic [SIDE_W-1:0]   dh_q;
	logic [SIDE_W-1:0]   col_step_q;
	logic [SIDE_W-1:0]   col_frac_q;
	logic [SIDE_W-1:0]   row_step_q;
	logic [SIDE_W-1:0]   row_frac_q;
	logic [SIDE_W-1:0]   dest_col_q;
	logic [SIDE_W-1:0]   dest_row_q;
	logic [SIDE_W-1:0]   pick_col_q;
	logic [SIDE_W-1:0]   pick_row_q;
	logic [SIDE_W-1:0]   col_rem_q;
	logic [SIDE_W-1:0]   row_rem_q;
	logic                res_valid_q;
	logic                res_dark_q;
	logic [POS_W-1:0]    res_col_q;
	logic [POS_W-1:0]    res_row_q;
	logic                res_end_q;

	logic                scale;
	logic                w_long;
	logic [2*SIDE_W-1:0] prod_full;
	logic [SIDE_W-1:0]   size_fit;
	logic                pick_row_hit;
	logic                sel;
	logic                out_free;
	logic [SIDE_W:0]     col_rem_sum;
	logic [SIDE_W:0]     row_rem_sum;
	logic                col_wrap;
	logic                row_wrap;
	logic [SIDE_W:0]     pick_col_sum;
	logic [SIDE_W:0]     pick_row_sum;
	logic                col_last;
	logic                row_last;

	assign scale     = (m_q != '0) && ((w_q > m_q) || (h_q > m_q));
	assign w_long    = w_q >= h_q;
	assign prod_full = (w_long ? h_q : w_q) * m_q;
	assign size_fit  = (div_res.quot[SIDE_W-1:0] == '0) ? SIDE_W'(1) : div_res.quot[SIDE_W-1:0];

	assign pick_row_hit = {1'b0, head.row} == pick_row_q;
	assign sel          = pick_row_hit && ({1'b0, head.col} == pick_col_q);
	assign out_free     = !res_valid_q || res.ready;

	assign col_rem_sum  = {1'b0, col_rem_q} + {1'b0, col_frac_q};
	assign row_rem_sum  = {1'b0, row_rem_q} + {1'b0, row_frac_q};
	assign col_wrap     = col_rem_sum >= {1'b0, dw_q};
	assign row_wrap     = row_rem_sum >= {1'b0, dh_q};
	assign pick_col_sum = {1'b0, pick_col_q} + {1'b0, col_step_q} + (SIDE_W+1)'(col_wrap);
	assign pick_row_sum = {1'b0, pick_row_q} + {1'b0, row_step_q} + (SIDE_W+1)'(row_wrap);
	assign col_last     = ({1'b0, dest_col_q} + (SIDE_W+1)'(1)) == {1'b0, dw_q};
	assign row_last     = ({1'b0, dest_row_q} + (SIDE_W+1)'(1)) == {1'b0, dh_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		div_req  = '0;
		setup_go = 1'b0;
		pop      = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				if (q_valid && head.first && !setup_done_q) begin
					setup_go = 1'b1;
					state_d  = ST_MUL;
				end else begin
					pop = q_valid && (!sel || out_free);
				end
			end
			ST_MUL: begin
				state_d = scale ? ST_SIZE_GO : ST_COL_GO;
			end
			ST_SIZE_GO: begin
				div_req = '{start: 1'b1, dividend: prod_q, divisor: divisor_q};
				state_d = ST_SIZE_WAIT;
			end
			ST_SIZE_WAIT: begin
				if (div_res.done) begin
					state_d = ST_COL_GO;
				end
			end
			ST_COL_GO: begin
				div_req = '{start: 1'b1, dividend: PROD_W'(w_q), divisor: dw_q};
				state_d = ST_COL_WAIT;
			end
			ST_COL_WAIT: begin
				if (div_res.done) begin
					state_d = ST_ROW_GO;
				end
			end
			ST_ROW_GO: begin
				div_req = '{start: 1'b1, dividend: PROD_W'(h_q), divisor: dh_q};
				state_d = ST_ROW_WAIT;
			end
			ST_ROW_WAIT: begin
				if (div_res.done) begin
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_done_q <= 1'b0;
			w_q          <= '0;
			h_q          <= '0;
			m_q          <= '0;
			short_is_h_q <= 1'b0;
			prod_q       <= '0;
			divisor_q    <= '0;
			dw_q         <= '0;
			dh_q         <= '0;
			col_step_q   <= '0;
			col_frac_q   <= '0;
			row_step_q   <= '0;
			row_frac_q   <= '0;
			dest_col_q   <= '0;
			dest_row_q   <= '0;
			pick_col_q   <= '0;
			pick_row_q   <= '0;
			col_rem_q    <= '0;
			row_rem_q    <= '0;
			res_valid_q  <= 1'b0;
			res_dark_q   <= 1'b0;
			res_col_q    <= '0;
			res_row_q    <= '0;
			res_end_q    <= 1'b0;
		end else begin
			if (setup_go) begin
				w_q <= clamp_side(cfg.src_width);
				h_q <= clamp_side(cfg.src_height);
				m_q <= cfg.max_side;
			end
			if (state_q == ST_MUL) begin
				prod_q       <= prod_full[PROD_W-1:0];
				divisor_q    <= w_long ? w_q : h_q;
				short_is_h_q <= w_long;
				if (scale) begin
					if (w_long) begin
						dw_q <= m_q;
					end else begin
						dh_q <= m_q;
					end
				end else begin
					dw_q <= w_q;
					dh_q <= h_q;
				end
			end
			if (state_q == ST_SIZE_WAIT && div_res.done) begin
				if (short_is_h_q) begin
					dh_q <= size_fit;
				end else begin
					dw_q <= size_fit;
				end
			end
			if (state_q == ST_COL_WAIT && div_res.done) begin
				col_step_q <= div_res.quot[SIDE_W-1:0];
				col_frac_q <= div_res.rem;
			end
			if (state_q == ST_ROW_WAIT && div_res.done) begin
				row_step_q   <= div_res.quot[SIDE_W-1:0];
				row_frac_q   <= div_res.rem;
				setup_done_q <= 1'b1;
				dest_col_q   <= '0;
				dest_row_q   <= '0;
				pick_col_q   <= '0;
				pick_row_q   <= '0;
				col_rem_q    <= '0;
				row_rem_q    <= '0;
			end

			if (pop) begin
				setup_done_q <= 1'b0;
				if (sel) begin
					dest_col_q <= dest_col_q + SIDE_W'(1);
					pick_col_q <= pick_col_sum[SIDE_W-1:0];
					col_rem_q  <= col_wrap ? SIDE_W'(col_rem_sum - {1'b0, dw_q})
						: col_rem_sum[SIDE_W-1:0];
				end
				if (head.row_end) begin
					if (pick_row_hit) begin
						dest_row_q <= dest_row_q + SIDE_W'(1);
						pick_row_q <= pick_row_sum[SIDE_W-1:0];
						row_rem_q  <= row_wrap ? SIDE_W'(row_rem_sum - {1'b0, dh_q})
							: row_rem_sum[SIDE_W-1:0];
					end
					dest_col_q <= '0;
					pick_col_q <= '0;
					col_rem_q  <= '0;
				end
			end

			if (pop && sel) begin
				res_valid_q <= 1'b1;
				res_dark_q  <= head.gray < cfg.dark_threshold;
				res_col_q   <= dest_col_q[POS_W-1:0];
				res_row_q   <= dest_row_q[POS_W-1:0];
				res_end_q   <= col_last && row_last;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid     = res_valid_q;
	assign res.dark      = res_dark_q;
	assign res.out_col   = res_col_q;
	assign res.out_row   = res_row_q;
	assign res.frame_end = res_end_q;

	assign stat = '{setup_busy: state_q != ST_RUN, setup_done: setup_done_q,
		pop: pop, pop_first: pop && head.first};

endmodule

// ===== verif/tb_top.sv =====
// Testbench for gray_fit_downscale_threshold: streams grayscale frames in raster order,
// predicts the downscaled dark marks in a scoreboard class and checks every result request.
// Depends on gfdt_pkg, the gfdt_pix_if and gfdt_res_if interfaces and the block itself.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import gfdt_pkg::*;

	localparam int LIMIT        = 1_500_000;
	localparam int DRAIN        = 200;
	localparam int RANDOM_ITEMS = 1000;
	localparam int HOLD_CYCLES  = 400;
	localparam int SAT_ITEMS    = 300;

	typedef struct packed {
		logic             dark;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             frame_end;
	} mark_t;

	class downscale_scoreboard;
		logic [SIDE_W-1:0] width_reg, height_reg, limit_reg;
		logic [GRAY_W-1:0] thresh_reg;
		logic [SIDE_W-1:0] src_col, src_row, out_x, out_y, out_w, out_h;
		logic [SIDE_W-1:0] pick_col, pick_row, col_acc, row_acc;
		logic [SIDE_W-1:0] frame_w, frame_h, col_q, col_r, row_q, row_r;
		mark_t marks[$];
		int errors;

		function new();
			width_reg = 1;
			height_reg = 1;
			limit_reg = 0;
			thresh_reg = THRESH_RESET;
			src_col = 0;
			src_row = 0;
			out_x = 0;
			out_y = 0;
			out_w = 0;
			out_h = 0;
			pick_col = 0;
			pick_row = 0;
			col_acc = 0;
			row_acc = 0;
			frame_w = 0;
			frame_h = 0;
			col_q = 0;
			col_r = 0;
			row_q = 0;
			row_r = 0;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
			case (idx)
				REG_SRC_WIDTH: width_reg = value[SIDE_W-1:0];
				REG_SRC_HEIGHT: height_reg = value[SIDE_W-1:0];
				REG_MAX_SIDE: limit_reg = value[SIDE_W-1:0];
				REG_DARK_THRESHOLD: thresh_reg = value[GRAY_W-1:0];
				default: ;
			endcase
		endfunction

		function int fit_side(logic [SIDE_W-1:0] v);
			if (v == 0) return 1;
			if (v > MAX_SIDE) return int'(MAX_SIDE);
			return int'(v);
		endfunction

		function void open_frame();
			int w, h, m, dw, dh;
			w = fit_side(width_reg);
			h = fit_side(height_reg);
			m = int'(limit_reg);
			dw = w;
			dh = h;
			if (m > 0 && (w > m || h > m)) begin
				if (w >= h) begin
					dw = m;
					dh = (h * m) / w;
				end else begin
					dh = m;
					dw = (w * m) / h;
				end
				if (dw < 1) dw = 1;
				if (dh < 1) dh = 1;
			end
			frame_w = SIDE_W'(w);
			frame_h = SIDE_W'(h);
			out_w = SIDE_W'(dw);
			out_h = SIDE_W'(dh);
			col_q = SIDE_W'(w / dw);
			col_r = SIDE_W'(w % dw);
			row_q = SIDE_W'(h / dh);
			row_r = SIDE_W'(h % dh);
			out_x = 0;
			out_y = 0;
			pick_col = 0;
			pick_row = 0;
			col_acc = 0;
			row_acc = 0;
		endfunction

		function void note_pixel(logic [GRAY_W-1:0] g);
			logic row_hit;
			mark_t mark;
			if (src_col == 0 && src_row == 0) open_frame();
			row_hit = (src_row == pick_row);
			if (row_hit && src_col == pick_col) begin
				mark.dark = (g < thresh_reg);
				mark.col = out_x[POS_W-1:0];
				mark.row = out_y[POS_W-1:0];
				mark.frame_end = (int'(out_x) + 1 == int'(out_w)) &&
					(int'(out_y) + 1 == int'(out_h));
				marks.push_back(mark);
				out_x = out_x + 1;
				pick_col = pick_col + col_q;
				col_acc = col_acc + col_r;
				if (col_acc >= out_w) begin
					col_acc = col_acc - out_w;
					pick_col = pick_col + 1;
				end
			end
			src_col = src_col + 1;
			if (src_col >= frame_w) begin
				src_col = 0;
				if (row_hit) begin
					out_y = out_y + 1;
					pick_row = pick_row + row_q;
					row_acc = row_acc + row_r;
					if (row_acc >= out_h) begin
						row_acc = row_acc - out_h;
						pick_row = pick_row + 1;
					end
				end
				out_x = 0;
				pick_col = 0;
				col_acc = 0;
				src_row = src_row + 1;
				if (src_row >= frame_h) src_row = 0;
			end
		endfunction

		function int pixels_left();
			if (src_col == 0 && src_row == 0) return 0;
			return int'(frame_w) * int'(frame_h) - (int'(src_row) * int'(frame_w) + int'(src_col));
		endfunction

		function int next_frame_size();
			return fit_side(width_reg) * fit_side(height_reg);
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_mark(mark_t got);
			mark_t want;
			if (marks.size() == 0) begin
				report($sformatf("result col %0d row %0d with none expected", got.col, got.row));
				return;
			end
			want = marks.pop_front();
			if (got.dark != want.dark)
				report($sformatf("dark %0d, expected %0d", got.dark, want.dark));
			if (got.col != want.col)
				report($sformatf("out_col %0d, expected %0d", got.col, want.col));
			if (got.row != want.row)
				report($sformatf("out_row %0d, expected %0d", got.row, want.row));
			if (got.frame_end != want.frame_end)
				report($sformatf("frame_end %0d, expected %0d at col %0d row %0d",
					got.frame_end, want.frame_end, want.col, want.row));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int cycles = 0;
	int pixels_sent = 0;
	int results_seen = 0;
	bit no_gaps = 1'b0;
	bit hold_req = 1'b0;

	downscale_scoreboard sb = new();

	gfdt_pix_if pix_ch ();
	gfdt_res_if res_ch ();

	gray_fit_downscale_threshold dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("gray_fit_downscale_threshold test failed");
			$finish;
		end
	end

	task apb_write(reg_idx_t idx, int value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = DATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, DATA_W'(value));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task send_pixel(logic [GRAY_W-1:0] g);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			pix_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_ch.valid = 1'b1;
		pix_ch.gray_level = g;
		do @(posedge clk); while (!pix_ch.ready);
		sb.note_pixel(g);
		pixels_sent++;
	endtask

	function logic [GRAY_W-1:0] pick_gray();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return sb.thresh_reg - 8'd1;
			3: return sb.thresh_reg;
			default: return GRAY_W'($urandom_range(0, 255));
		endcase
	endfunction

	task send_run(int n);
		repeat (n) send_pixel(pick_gray());
	endtask

	// Waits for the last mark, then lets pixels that give no mark clear the block.
	task settle();
		@(negedge clk);
		pix_ch.valid = 1'b0;
		while (sb.marks.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task random_config();
		case ($urandom_range(0, 9))
			0: apb_write(REG_SRC_WIDTH, 0);
			1: apb_write(REG_SRC_WIDTH, $urandom_range(25, 64));
			default: apb_write(REG_SRC_WIDTH, $urandom_range(1, 24));
		endcase
		case ($urandom_range(0, 9))
			0: apb_write(REG_SRC_HEIGHT, 0);
			default: apb_write(REG_SRC_HEIGHT, $urandom_range(1, 12));
		endcase
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 5))
				0: apb_write(REG_MAX_SIDE, 0);
				1: apb_write(REG_MAX_SIDE, 1);
				2: apb_write(REG_MAX_SIDE, 4096);
				3: apb_write(REG_MAX_SIDE, 8191);
				default: apb_write(REG_MAX_SIDE, $urandom_range(1, 24));
			endcase
		end
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 5))
				0: apb_write(REG_DARK_THRESHOLD, 0);
				1: apb_write(REG_DARK_THRESHOLD, 255);
				default: apb_write(REG_DARK_THRESHOLD, $urandom_range(0, 255));
			endcase
		end
	endtask

	initial begin
		int stall;
		mark_t got;
		res_ch.ready = 1'b0;
		forever begin
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				stall = no_gaps ? 0 : $urandom_range(0, 11);
			end
			@(negedge clk);
			if (stall > 0) begin
				res_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			got.dark = res_ch.dark;
			got.col = res_ch.out_col;
			got.row = res_ch.out_row;
			got.frame_end = res_ch.frame_end;
			sb.check_mark(got);
			results_seen++;
		end
	end

	initial begin
		int phase, base, frames, size;
		pix_ch.valid = 1'b0;
		pix_ch.gray_level = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_pixel(8'd0);
		send_pixel(8'd127);
		send_pixel(8'd128);
		send_pixel(8'd255);
		settle();
		apb_write(REG_SRC_WIDTH, 0);
		apb_write(REG_SRC_HEIGHT, 0);
		apb_write(REG_DARK_THRESHOLD, 0);
		send_pixel(8'd0);
		settle();
		apb_write(REG_DARK_THRESHOLD, 255);
		send_pixel(8'd254);
		send_pixel(8'd255);
		settle();
		apb_write(REG_SRC_WIDTH, 3);
		apb_write(REG_SRC_HEIGHT, 3);
		apb_write(REG_MAX_SIDE, 2);
		apb_write(REG_DARK_THRESHOLD, 128);
		send_run(9);
		settle();
		apb_write(REG_SRC_WIDTH, 2);
		apb_write(REG_SRC_HEIGHT, 5);
		apb_write(REG_MAX_SIDE, 3);
		send_run(10);
		settle();

		base = pixels_sent;
		phase = 0;
		while (phase < 6 || pixels_sent - base < RANDOM_ITEMS || results_seen < 60) begin
			if (phase == 2) begin
				apb_write(REG_SRC_WIDTH, 64);
				apb_write(REG_SRC_HEIGHT, 2);
				apb_write(REG_MAX_SIDE, 0);
				hold_req = 1'b1;
			end else if (phase == 5) begin
				apb_write(REG_SRC_WIDTH, 1);
				apb_write(REG_SRC_HEIGHT, 40);
				apb_write(REG_MAX_SIDE, 8191);
			end else begin
				random_config();
			end
			no_gaps = ($urandom_range(0, 3) == 0);
			send_run(sb.pixels_left());
			frames = (phase == 2 || phase == 5) ? 1 : $urandom_range(1, 3);
			send_run(frames * sb.next_frame_size());
			if ($urandom_range(0, 4) == 0) begin
				size = sb.next_frame_size();
				if (size > 1) send_run($urandom_range(1, size - 1));
			end
			settle();
			phase++;
		end

		// The last frame is left open; its first row shows the saturated width in the step.
		send_run(sb.pixels_left());
		settle();
		apb_write(REG_SRC_WIDTH, 8191);
		apb_write(REG_SRC_HEIGHT, 8191);
		apb_write(REG_MAX_SIDE, 16);
		send_run(SAT_ITEMS);
		settle();

		if (sb.errors == 0 && sb.marks.size() == 0) begin
			$display("gray_fit_downscale_threshold test passed");
		end else begin
			$display("gray_fit_downscale_threshold test failed");
		end
		$finish;
	end

endmodule

// ===== gray_fit_downscale_threshold.f =====
rtl/core/gfdt_pkg.sv
rtl/core/gfdt_if.sv
rtl/core/gfdt_div.sv
rtl/core/gfdt_fifo.sv
rtl/core/gfdt_front.sv
rtl/core/gfdt_back.sv
rtl/core/gray_fit_downscale_threshold.sv
verif/tb_top.sv
